### rtl/core/erp_pkg.sv
// shared types and constants for the encoder position and rpm block
package erp_pkg;

  localparam int COUNTER_BITS_DEF = 16;
  localparam int CPR_W            = 24;
  localparam int POS_W            = 32;
  localparam int TIME_W           = 32;
  // |delta| <= 2^31 times 60000 stays below 2^47
  localparam int NUM_W            = 48;
  localparam int DEN_W            = CPR_W + TIME_W;
  localparam int CNT_W            = $clog2(NUM_W);
  localparam int MUL_W            = 32;

  localparam logic [MUL_W-1:0] MS_PER_MIN = MUL_W'(60000);

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_SPEED  = 2'd1,
    CMD_SET    = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SPD_NONE = 2'd0,
    SPD_OK   = 2'd1,
    SPD_ZERO = 2'd2,
    SPD_SAT  = 2'd3
  } spd_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DPOS,
    S_MUL_NUM,
    S_MUL_DEN,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

endpackage

### rtl/core/encoder_position_rpm.sv
// encoder position extension and rpm computation with a shared multiplier and serial divider
//
//  channel | signals                                   | direction | handshake
//  in      | in_cmd, in_counter_value, in_now_ms,      | input     | in_valid/in_ready
//          | in_new_position                           |           |
//  out     | out_position, out_rpm, out_speed_status   | output    | out_valid/out_ready
//  cfg     | cfg_wr_data (encoder counts per rev)      | input     | cfg_wr_en, no wait
//
// update and set requests go from accept to the done state, then into the output register once out_ready allows
// speed requests run a delta step, two passes of the shared 32x32
// multiplier, 48 steps of the restoring divider and a saturation step
// zero-interval speed requests finish after the delta step
// one request at a time; in_ready returns once the result is in the output register
// synchronous active-low reset, no clearing pass; a stalled out_ready holds the result
module encoder_position_rpm #(
  parameter int COUNTER_BITS = erp_pkg::COUNTER_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [erp_pkg::CPR_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_cmd,
  input  logic [15:0]               in_counter_value,
  input  logic [31:0]               in_now_ms,
  input  logic signed [31:0]        in_new_position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [31:0]        out_position,
  output logic signed [31:0]        out_rpm,
  output logic [1:0]                out_speed_status
);
  import erp_pkg::*;

  state_t                  state_r, state_nxt;
  logic [CPR_W-1:0]        cpr_r;
  logic [COUNTER_BITS-1:0] last_cnt_r, last_cnt_nxt;
  logic [POS_W-1:0]        accum_r, accum_nxt;
  logic [TIME_W-1:0]       prev_time_r, prev_time_nxt;
  logic [POS_W-1:0]        prev_spd_r, prev_spd_nxt;
  logic [TIME_W-1:0]       dt_r, dt_nxt;
  logic                    neg_r, neg_nxt;
  logic [POS_W-1:0]        mag_r, mag_nxt;
  logic [DEN_W-1:0]        den_r, den_nxt;
  logic [NUM_W-1:0]        quo_r, quo_nxt;
  logic [DEN_W-1:0]        rem_r, rem_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [POS_W-1:0]        rpm_r, rpm_nxt;
  spd_status_t             status_r, status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]        out_pos_r, out_pos_nxt;
  logic [POS_W-1:0]        out_rpm_r, out_rpm_nxt;
  spd_status_t             out_status_r, out_status_nxt;

  logic [31:0]             raw_ext;
  logic [COUNTER_BITS-1:0] cur_cnt;
  logic [COUNTER_BITS-1:0] cnt_diff;
  logic [POS_W-1:0]        delta_ext;
  logic [POS_W-1:0]        dpos;
  logic [CPR_W-1:0]        cpr_eff;
  logic [MUL_W-1:0]        mul_a, mul_b;
  logic [2*MUL_W-1:0]      mul_p;
  logic [DEN_W:0]          trial;
  logic                    trial_ge;
  logic                    sat_pos, sat_neg;
  logic                    accept;
  cmd_t                    cmd;

  assign raw_ext   = {16'b0, in_counter_value};
  assign cur_cnt   = raw_ext[COUNTER_BITS-1:0];
  assign cnt_diff  = cur_cnt - last_cnt_r;
  assign delta_ext = POS_W'($signed(cnt_diff));
  assign dpos      = accum_r - prev_spd_r;
  assign cpr_eff   = (cpr_r == '0) ? CPR_W'(1) : cpr_r;
  assign cmd       = cmd_t'(in_cmd);

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;

  // shared multiplier: numerator pass, then denominator pass
  assign mul_a = (state_r == S_MUL_NUM) ? mag_r : dt_r;
  assign mul_b = (state_r == S_MUL_NUM) ? MS_PER_MIN : MUL_W'(cpr_eff);
  assign mul_p = mul_a * mul_b;

  // one restoring division step per cycle, dividend shifted out of quo_r
  assign trial    = {rem_r, quo_r[NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, den_r});

  assign sat_pos = |quo_r[NUM_W-1:31];
  assign sat_neg = (|quo_r[NUM_W-1:32]) || (quo_r[31] && (|quo_r[30:0]));

  always_comb begin
    state_nxt      = state_r;
    last_cnt_nxt   = last_cnt_r;
    accum_nxt      = accum_r;
    prev_time_nxt  = prev_time_r;
    prev_spd_nxt   = prev_spd_r;
    dt_nxt         = dt_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    den_nxt        = den_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    rpm_nxt        = rpm_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_pos_nxt    = out_pos_r;
    out_rpm_nxt    = out_rpm_r;
    out_status_nxt = out_status_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          rpm_nxt    = '0;
          status_nxt = SPD_NONE;
          state_nxt  = S_DONE;
          if (cmd == CMD_SET) begin
            accum_nxt = in_new_position;
          end else begin
            accum_nxt    = accum_r + delta_ext;
            last_cnt_nxt = cur_cnt;
            if (cmd == CMD_SPEED) begin
              dt_nxt        = in_now_ms - prev_time_r;
              prev_time_nxt = in_now_ms;
              state_nxt     = S_DPOS;
            end
          end
        end
      end
      S_DPOS: begin
        prev_spd_nxt = accum_r;
        neg_nxt      = dpos[POS_W-1];
        mag_nxt      = dpos[POS_W-1] ? (~dpos + POS_W'(1)) : dpos;
        if (dt_r == '0) begin
          status_nxt = SPD_ZERO;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_MUL_NUM;
        end
      end
      S_MUL_NUM: begin
        quo_nxt   = mul_p[NUM_W-1:0];
        state_nxt = S_MUL_DEN;
      end
      S_MUL_DEN: begin
        den_nxt   = mul_p[DEN_W-1:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        quo_nxt = {quo_r[NUM_W-2:0], trial_ge};
        rem_nxt = trial_ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        status_nxt = SPD_OK;
        if (neg_r) begin
          if (sat_neg) begin
            rpm_nxt    = 32'h8000_0000;
            status_nxt = SPD_SAT;
          end else begin
            rpm_nxt = ~quo_r[31:0] + 32'd1;
          end
        end else begin
          if (sat_pos) begin
            rpm_nxt    = 32'h7FFF_FFFF;
            status_nxt = SPD_SAT;
          end else begin
            rpm_nxt = quo_r[31:0];
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_pos_nxt    = accum_r;
          out_rpm_nxt    = rpm_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cpr_r       <= CPR_W'(1);
      last_cnt_r  <= '0;
      accum_r     <= '0;
      prev_time_r <= '0;
      prev_spd_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_cnt_r  <= last_cnt_nxt;
      accum_r     <= accum_nxt;
      prev_time_r <= prev_time_nxt;
      prev_spd_r  <= prev_spd_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cpr_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    dt_r         <= dt_nxt;
    neg_r        <= neg_nxt;
    mag_r        <= mag_nxt;
    den_r        <= den_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    rpm_r        <= rpm_nxt;
    status_r     <= status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_rpm_r    <= out_rpm_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_position     = out_pos_r;
  assign out_rpm          = out_rpm_r;
  assign out_speed_status = out_status_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("in_ready high right after a request was taken");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CNT_W'(NUM_W)))
    else $error("divider step count out of range");

  a_no_speed_rpm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == SPD_NONE || out_status_r == SPD_ZERO))
      |-> (out_rpm_r == '0))
    else $error("rpm nonzero without a computed speed");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == SPD_SAT)
      |-> (out_rpm_r == 32'h7FFF_FFFF || out_rpm_r == 32'h8000_0000))
    else $error("saturated rpm is not a limit value");

  a_speed_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DPOS) |=> (prev_spd_r == accum_r))
    else $error("speed reference position not captured");

endmodule
